/* hdl/pnepo_pkg.sv */
`default_nettype none
package pnepo_pkg;

    localparam int LIMIT_W = 23;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd256000;

    // Handshake from the edge engine back to the polygon sequencer.
    typedef struct packed {
        logic done;
        logic hit;
    } edge_status_t;

endpackage
`default_nettype wire

/* hdl/pnepo_vertex_if.sv */
`default_nettype none
interface pnepo_vertex_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, point_x, point_y, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, point_x, point_y, last_vertex,
        output ready
    );
endinterface
`default_nettype wire

/* hdl/pnepo_result_if.sv */
`default_nettype none
interface pnepo_result_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] move_x;
    logic signed [COORD_BITS-1:0] move_y;
    logic                         edge_found;

    modport source (
        output valid, move_x, move_y, edge_found,
        input  ready
    );
    modport sink (
        input  valid, move_x, move_y, edge_found,
        output ready
    );
endinterface
`default_nettype wire

/* hdl/pnepo_div.sv */
`default_nettype none
module pnepo_div #(
    parameter int NUM_W = 75,
    parameter int DEN_W = 50,
    parameter int QW    = 26
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic                  ovf,
    output logic [QW-1:0]         quo
);
    localparam int DSH_W = DEN_W + QW - 1;
    localparam int R_W   = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int OV_W  = ((DEN_W + QW) > NUM_W) ? (DEN_W + QW) : NUM_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [R_W-1:0]   rem_reg, rem_next;
    logic [R_W-1:0]   dsh_reg, dsh_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic             ovf_reg, ovf_next;
    logic             ge;

    assign ge = rem_reg >= dsh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QW);
            rem_next  = R_W'(num);
            dsh_next  = R_W'(den) << (QW - 1);
            quo_next  = '0;
            // quotient too wide for QW bits
            ovf_next  = OV_W'(num) >= (OV_W'(den) << QW);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[QW-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

/* hdl/pnepo_edge.sv */
`default_nettype none
module pnepo_edge #(
    parameter int COORD_BITS = 24,
    parameter int BD_W       = 48
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [COORD_BITS-1:0] ax,
    input  wire logic signed [COORD_BITS-1:0] ay,
    input  wire logic signed [COORD_BITS-1:0] bx,
    input  wire logic signed [COORD_BITS-1:0] by,
    input  wire logic signed [COORD_BITS-1:0] px,
    input  wire logic signed [COORD_BITS-1:0] py,
    input  wire logic [BD_W-1:0]              best,
    output pnepo_pkg::edge_status_t           status,
    output logic [BD_W-1:0]                   dist2,
    output logic signed [COORD_BITS-1:0]      dx,
    output logic signed [COORD_BITS-1:0]      dy
);
    import pnepo_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int EW    = CW + 1;
    localparam int PW    = 2 * EW;
    localparam int DOT_W = PW + 1;
    localparam int NUM_W = PW + EW;
    localparam int QW    = CW + 2;
    localparam int SW    = CW + 4;
    localparam int CMP_W = (PW > BD_W) ? PW : BD_W;
    localparam logic signed [SW-1:0] D_LIM = SW'(64'd1 << (CW - 1));

    typedef enum logic [15:0] {
        S_IDLE = 16'b0000_0000_0000_0001,
        S_DIFF = 16'b0000_0000_0000_0010,
        S_LEN0 = 16'b0000_0000_0000_0100,
        S_LEN1 = 16'b0000_0000_0000_1000,
        S_DOT0 = 16'b0000_0000_0001_0000,
        S_DOT1 = 16'b0000_0000_0010_0000,
        S_DOTF = 16'b0000_0000_0100_0000,
        S_PK0  = 16'b0000_0000_1000_0000,
        S_PK1  = 16'b0000_0001_0000_0000,
        S_PK2  = 16'b0000_0010_0000_0000,
        S_DST  = 16'b0000_0100_0000_0000,
        S_DIV  = 16'b0000_1000_0000_0000,
        S_OFF  = 16'b0001_0000_0000_0000,
        S_SQ0  = 16'b0010_0000_0000_0000,
        S_SQ1  = 16'b0100_0000_0000_0000,
        S_SQ2  = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;

    logic signed [EW-1:0]    e_x_reg, e_x_next, e_y_reg, e_y_next;
    logic signed [EW-1:0]    w_x_reg, w_x_next, w_y_reg, w_y_next;
    logic [PW-1:0]           prod_reg, prod_next;
    logic [PW-1:0]           len_reg, len_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic signed [CW-1:0]    d_x_reg, d_x_next, d_y_reg, d_y_next;
    logic [PW-1:0]           d2_reg, d2_next;
    logic                    t_neg_reg, t_neg_next;

    logic [EW-1:0]           op_a, op_b;
    logic [EW-1:0]           k_mag;
    logic [PW-1:0]           dot_mag;
    logic signed [DOT_W-1:0] term;
    logic                    off_neg;
    logic signed [SW-1:0]    off_s, w_ext, diff;
    logic [PW-1:0]           sq_sum;
    logic                    div_start, div_done, div_ovf;
    logic [QW-1:0]           div_quo;

    function automatic logic [EW-1:0] mag_of(input logic signed [EW-1:0] v);
        return v[EW-1] ? EW'(-v) : EW'(v);
    endfunction

    pnepo_div #(
        .NUM_W(NUM_W),
        .DEN_W(PW),
        .QW   (QW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (num_reg),
        .den  (len_reg),
        .done (div_done),
        .ovf  (div_ovf),
        .quo  (div_quo)
    );

    assign k_mag   = mag_of(axis_reg ? e_y_reg : e_x_reg);
    assign dot_mag = PW'(dot_reg[DOT_W-1] ? -dot_reg : dot_reg);
    assign term    = t_neg_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
    assign off_neg = (axis_reg ? e_y_reg[EW-1] : e_x_reg[EW-1]) ^ dot_reg[DOT_W-1];
    assign off_s   = off_neg ? -$signed(SW'(div_quo)) : $signed(SW'(div_quo));
    assign w_ext   = SW'(axis_reg ? w_y_reg : w_x_reg);
    assign diff    = w_ext - off_s;
    assign sq_sum  = d2_reg + prod_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        e_x_next   = e_x_reg;
        e_y_next   = e_y_reg;
        w_x_next   = w_x_reg;
        w_y_next   = w_y_reg;
        len_next   = len_reg;
        dot_next   = dot_reg;
        num_next   = num_reg;
        d_x_next   = d_x_reg;
        d_y_next   = d_y_reg;
        d2_next    = d2_reg;
        t_neg_next = t_neg_reg;
        op_a       = '0;
        op_b       = '0;
        div_start  = 1'b0;
        status     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                e_x_next   = EW'(bx) - EW'(ax);
                e_y_next   = EW'(by) - EW'(ay);
                w_x_next   = EW'(px) - EW'(ax);
                w_y_next   = EW'(py) - EW'(ay);
                state_next = S_LEN0;
            end
            S_LEN0:
            begin
                op_a       = mag_of(e_x_reg);
                op_b       = mag_of(e_x_reg);
                state_next = S_LEN1;
            end
            S_LEN1:
            begin
                len_next   = prod_reg;
                op_a       = mag_of(e_y_reg);
                op_b       = mag_of(e_y_reg);
                state_next = S_DOT0;
            end
            S_DOT0:
            begin
                len_next   = len_reg + prod_reg;
                op_a       = mag_of(e_x_reg);
                op_b       = mag_of(w_x_reg);
                t_neg_next = e_x_reg[EW-1] ^ w_x_reg[EW-1];
                state_next = S_DOT1;
            end
            S_DOT1:
            begin
                dot_next   = term;
                op_a       = mag_of(e_y_reg);
                op_b       = mag_of(w_y_reg);
                t_neg_next = e_y_reg[EW-1] ^ w_y_reg[EW-1];
                state_next = S_DOTF;
            end
            S_DOTF:
            begin
                dot_next  = dot_reg + term;
                axis_next = 1'b0;
                // skip a zero-length edge
                if (len_reg == '0)
                begin
                    status.done = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_PK0;
                end
            end
            S_PK0:
            begin
                op_a       = k_mag;
                op_b       = dot_mag[EW-1:0];
                state_next = S_PK1;
            end
            S_PK1:
            begin
                num_next   = NUM_W'(prod_reg);
                op_a       = k_mag;
                op_b       = dot_mag[PW-1:EW];
                state_next = S_PK2;
            end
            S_PK2:
            begin
                num_next   = num_reg + (NUM_W'(prod_reg) << EW);
                state_next = S_DST;
            end
            S_DST:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OFF;
                end
            end
            S_OFF:
            begin
                // drop the edge on divider overflow or if the residual leaves the coordinate range
                if (div_ovf || !(diff < D_LIM) || !(diff > -D_LIM))
                begin
                    status.done = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (!axis_reg)
                begin
                    d_x_next   = CW'(diff);
                    axis_next  = 1'b1;
                    state_next = S_PK0;
                end
                else
                begin
                    d_y_next   = CW'(diff);
                    state_next = S_SQ0;
                end
            end
            S_SQ0:
            begin
                op_a       = mag_of(EW'(d_x_reg));
                op_b       = mag_of(EW'(d_x_reg));
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                d2_next    = prod_reg;
                op_a       = mag_of(EW'(d_y_reg));
                op_b       = mag_of(EW'(d_y_reg));
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                status.done = 1'b1;
                status.hit  = CMP_W'(sq_sum) < CMP_W'(best);
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shared multiplier, product registered
    assign prod_next = PW'(op_a) * PW'(op_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_x_reg   <= e_x_next;
        e_y_reg   <= e_y_next;
        w_x_reg   <= w_x_next;
        w_y_reg   <= w_y_next;
        prod_reg  <= prod_next;
        len_reg   <= len_next;
        dot_reg   <= dot_next;
        num_reg   <= num_next;
        d_x_reg   <= d_x_next;
        d_y_reg   <= d_y_next;
        d2_reg    <= d2_next;
        t_neg_reg <= t_neg_next;
    end

    assign dist2 = BD_W'(sq_sum);
    assign dx    = d_x_reg;
    assign dy    = d_y_reg;
endmodule
`default_nettype wire

/* hdl/polygon_nearest_edge_push_out.sv */
// Each edge runs the shared multiplier steps and, once per axis, the one-bit-per-cycle
//   restoring divider.
// Throughput: a vertex that closes an edge takes one edge time, the last vertex two,
//   an opening vertex no edge unless last; the block is not ready in T_EDGE or T_OUT.
// Reset: rst_n is asynchronous, active low; it clears all control state, the open
//   polygon and the output valid, and loads the search limit with 1000.0 (Q15.8).
`default_nettype none
module polygon_nearest_edge_push_out #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    pnepo_vertex_if.sink                       vertex,
    pnepo_result_if.source                     result,
    input  wire logic                          cfg_we,
    input  wire logic [pnepo_pkg::LIMIT_W-1:0] cfg_wdata
);
    import pnepo_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int BD_W = (2 * CW > 2 * LIMIT_W) ? 2 * CW : 2 * LIMIT_W;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_EDGE = 3'b010,
        T_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [LIMIT_W-1:0]   limit_reg;
    logic                 inside_reg, inside_next;
    logic                 start_reg, start_next;
    logic                 sel_reg, sel_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg, found_next;
    logic signed [CW-1:0] vtx_x_reg, vtx_x_next, vtx_y_reg, vtx_y_next;
    logic                 last_reg, last_next;
    logic signed [CW-1:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [CW-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [CW-1:0] p_x_reg, p_x_next, p_y_reg, p_y_next;
    logic signed [CW-1:0] move_x_reg, move_x_next, move_y_reg, move_y_next;
    logic [BD_W-1:0]      best_reg, best_next;
    logic signed [CW-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic                 out_found_reg, out_found_next;

    logic [2*LIMIT_W-1:0] lim_sq;
    edge_status_t         st;
    logic [BD_W-1:0]      e_dist2;
    logic signed [CW-1:0] e_dx, e_dy;
    logic signed [CW-1:0] e_ax, e_ay, e_bx, e_by;

    assign lim_sq = (2 * LIMIT_W)'(limit_reg) * (2 * LIMIT_W)'(limit_reg);

    assign e_ax = sel_reg ? vtx_x_reg : prev_x_reg;
    assign e_ay = sel_reg ? vtx_y_reg : prev_y_reg;
    assign e_bx = sel_reg ? first_x_reg : vtx_x_reg;
    assign e_by = sel_reg ? first_y_reg : vtx_y_reg;

    pnepo_edge #(
        .COORD_BITS(CW),
        .BD_W      (BD_W)
    ) u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .ax    (e_ax),
        .ay    (e_ay),
        .bx    (e_bx),
        .by    (e_by),
        .px    (p_x_reg),
        .py    (p_y_reg),
        .best  (best_reg),
        .status(st),
        .dist2 (e_dist2),
        .dx    (e_dx),
        .dy    (e_dy)
    );

    assign vertex.ready = (state_reg == T_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        inside_next    = inside_reg;
        start_next     = 1'b0;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        vtx_x_next     = vtx_x_reg;
        vtx_y_next     = vtx_y_reg;
        last_next      = last_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        p_x_next       = p_x_reg;
        p_y_next       = p_y_reg;
        move_x_next    = move_x_reg;
        move_y_next    = move_y_reg;
        best_next      = best_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_found_next = out_found_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (vertex.valid)
                begin
                    vtx_x_next = vertex.vertex_x;
                    vtx_y_next = vertex.vertex_y;
                    last_next  = vertex.last_vertex;
                    if (!inside_reg)
                    begin
                        // open a polygon: latch the point, reset the best match
                        p_x_next     = vertex.point_x;
                        p_y_next     = vertex.point_y;
                        first_x_next = vertex.vertex_x;
                        first_y_next = vertex.vertex_y;
                        best_next    = BD_W'(lim_sq);
                        move_x_next  = vertex.point_x;
                        move_y_next  = vertex.point_y;
                        found_next   = 1'b0;
                        inside_next  = 1'b1;
                        if (vertex.last_vertex)
                        begin
                            sel_next   = 1'b1;
                            start_next = 1'b1;
                            state_next = T_EDGE;
                        end
                        else
                        begin
                            prev_x_next = vertex.vertex_x;
                            prev_y_next = vertex.vertex_y;
                        end
                    end
                    else
                    begin
                        sel_next   = 1'b0;
                        start_next = 1'b1;
                        state_next = T_EDGE;
                    end
                end
            end
            T_EDGE:
            begin
                if (st.done)
                begin
                    if (st.hit)
                    begin
                        best_next   = e_dist2;
                        move_x_next = e_dx;
                        move_y_next = e_dy;
                        found_next  = 1'b1;
                    end
                    if (!sel_reg && last_reg)
                    begin
                        // closing edge back to the first vertex
                        sel_next   = 1'b1;
                        start_next = 1'b1;
                    end
                    else if (sel_reg)
                    begin
                        inside_next = 1'b0;
                        state_next  = T_OUT;
                    end
                    else
                    begin
                        prev_x_next = vtx_x_reg;
                        prev_y_next = vtx_y_reg;
                        state_next  = T_IDLE;
                    end
                end
            end
            T_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_x_next     = move_x_reg;
                    out_y_next     = move_y_reg;
                    out_found_next = found_reg;
                    out_valid_next = 1'b1;
                    prev_x_next    = vtx_x_reg;
                    prev_y_next    = vtx_y_reg;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            limit_reg     <= LIMIT_RESET;
            inside_reg    <= 1'b0;
            start_reg     <= 1'b0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            best_reg      <= BD_W'(LIMIT_RESET) * BD_W'(LIMIT_RESET);
            move_x_reg    <= '0;
            move_y_reg    <= '0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            p_x_reg       <= '0;
            p_y_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            inside_reg    <= inside_next;
            start_reg     <= start_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            best_reg      <= best_next;
            move_x_reg    <= move_x_next;
            move_y_reg    <= move_y_next;
            first_x_reg   <= first_x_next;
            first_y_reg   <= first_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            p_x_reg       <= p_x_next;
            p_y_reg       <= p_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vtx_x_reg     <= vtx_x_next;
        vtx_y_reg     <= vtx_y_next;
        last_reg      <= last_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_found_reg <= out_found_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.move_x     = out_x_reg;
    assign result.move_y     = out_y_reg;
    assign result.edge_found = out_found_reg;
endmodule
`default_nettype wire
